/* src/edf_task_ready_table_core_assert.svh */
// Assertion macros shared by the task ready table RTL.
`ifndef EDF_TASK_READY_TABLE_CORE_ASSERT_SVH
`define EDF_TASK_READY_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define EDFQ_CHK_NOW(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define EDFQ_CHK_NEXT(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

/* src/edfq_pkg.sv */
// Shared types, codes and widths for the deadline-ordered task ready table.
`timescale 1ns / 1ps

package edfq_pkg;

  localparam int DEF_CAPACITY = 16;

  localparam int ID_W     = 8;
  localparam int TICK_W   = 32;
  localparam int ACTION_W = 2;
  localparam int KIND_W   = 3;
  localparam int COUNT_W  = 5;

  // task_id, deadline_offset, now
  localparam int IN_DATA_W  = 72;
  // out_task_id, elapsed_ticks, task_deadline, earliest_id, any_active,
  // active_count, two pad bits
  localparam int OUT_DATA_W = 88;

  localparam logic [ACTION_W-1:0] ACT_RELEASE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_COMPLETE = 2'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_RELEASED  = 3'd0,
    KIND_COMPLETED = 3'd1,
    KIND_OVERDUE   = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_FULL      = 3'd4,
    KIND_POLL_DONE = 3'd5
  } kind_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] deadline;
    logic [TICK_W-1:0] rel_tick;
  } entry_t;

  typedef struct packed {
    logic              lt;
    logic              eq;
    logic [TICK_W-1:0] diff;
  } alu_res_t;

endpackage

/* src/edfq_alu.sv */
// Shared 32-bit subtract unit: gives a - b, a < b and a == b.
`timescale 1ns / 1ps

module edfq_alu (
  input  logic [edfq_pkg::TICK_W-1:0] a,
  input  logic [edfq_pkg::TICK_W-1:0] b,
  output edfq_pkg::alu_res_t          res
);
  import edfq_pkg::*;

  logic [TICK_W:0] sub;

  assign sub      = {1'b0, a} - {1'b0, b};
  assign res.lt   = sub[TICK_W];
  assign res.diff = sub[TICK_W-1:0];
  assign res.eq   = (sub[TICK_W-1:0] == '0);

endmodule

/* src/edfq_ram.sv */
// Task table storage: one write port and one registered read port.
`timescale 1ns / 1ps

module edfq_ram #(
  parameter int DEPTH = edfq_pkg::DEF_CAPACITY,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  edfq_pkg::entry_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output edfq_pkg::entry_t rdata
);
  import edfq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds between reads so the sequencer can wait on the output.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/edf_task_ready_table_core.sv */
// Deadline-ordered task ready table with overdue sweep, release and complete.
`timescale 1ns / 1ps
`include "edf_task_ready_table_core_assert.svh"

// Channel  | Role   | Signals                                   | Moves
// s_*      | input  | s_tvalid s_tready s_tdata s_tuser         | one request per item
// m_*      | output | m_tvalid m_tready m_tdata m_tuser m_tlast | 1 to 17 results per request
//
// s_tready is high only in idle; a request is then accepted and goes through a sweep, a
// search, a head read, a read and a result per overdue task, a read and a write per entry
// moved by an insert or removal, and an insert write and a final step, all on one RAM port
// and one subtract unit. The table sits in a circular buffer, so removing overdue tasks
// moves nothing. Reset clears the count and the head pointer; the RAM needs no clearing.
// A stalled m_tready holds the output register and pauses the sequencer there.

module edf_task_ready_table_core #(
  parameter int CAPACITY = edfq_pkg::DEF_CAPACITY
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // task_id [7:0], deadline_offset [39:8], now [71:40]
  input  logic [edfq_pkg::IN_DATA_W-1:0]  s_tdata,
  // action [1:0]
  input  logic [edfq_pkg::ACTION_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_task_id [7:0], elapsed_ticks [39:8], task_deadline [71:40],
  // earliest_id [79:72], any_active [80], active_count [85:81], zero [87:86]
  output logic [edfq_pkg::OUT_DATA_W-1:0] m_tdata,
  // kind [2:0]
  output logic [edfq_pkg::KIND_W-1:0]     m_tuser,
  output logic                            m_tlast
);
  import edfq_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_SWEEP   = 11'b000_0000_0010,
    ST_SEARCH  = 11'b000_0000_0100,
    ST_HEAD_RD = 11'b000_0000_1000,
    ST_HEAD_WT = 11'b000_0001_0000,
    ST_OVD_RD  = 11'b000_0010_0000,
    ST_OVD_OUT = 11'b000_0100_0000,
    ST_MV_RD   = 11'b000_1000_0000,
    ST_MV_WR   = 11'b001_0000_0000,
    ST_INS_WR  = 11'b010_0000_0000,
    ST_FIN     = 11'b100_0000_0000
  } state_t;

  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(CAPACITY)) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return sum[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
    return (p == IW'(CAPACITY - 1)) ? '0 : p + IW'(1);
  endfunction

  function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] p);
    return (p == '0) ? IW'(CAPACITY - 1) : p - IW'(1);
  endfunction

  state_t state, state_next;

  // Committed table state.
  logic [IW-1:0] head;
  logic [CW-1:0] cnt;

  // Request being worked on.
  logic [ACTION_W-1:0] act;
  logic [ID_W-1:0]     tid;
  logic [TICK_W-1:0]   cur_tick;
  logic [TICK_W-1:0]   new_dl;

  // Sequencer registers.
  logic [IW-1:0] ptr;
  logic [CW-1:0] idx;
  logic [CW-1:0] lim;
  logic          rv;
  logic [CW-1:0] ridx;
  logic [CW-1:0] m;
  logic [IW-1:0] hd1;
  logic [CW-1:0] n1;
  logic [CW-1:0] pos;
  logic          found;
  logic [TICK_W-1:0] hit_rel;
  logic [TICK_W-1:0] hit_dl;
  logic [CW-1:0] li;
  logic [CW-1:0] fcnt;
  logic [ID_W-1:0] fearly;

  // Output register.
  kind_t              o_kind;
  logic [ID_W-1:0]    o_id;
  logic [TICK_W-1:0]  o_el;
  logic [TICK_W-1:0]  o_dl;
  logic [ID_W-1:0]    o_early;
  logic               o_any;
  logic [COUNT_W-1:0] o_cnt;
  logic               o_last;

  // RAM and shared unit.
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  entry_t        rdata;
  logic [TICK_W-1:0] alu_a;
  logic [TICK_W-1:0] alu_b;
  alu_res_t      alu;

  logic          is_rel;
  logic          is_cmp;
  logic          full;
  logic          rel_ok;
  logic          out_free;
  logic          scan_re;
  logic          scan_hit;
  logic          scan_end;
  logic [CW-1:0] scan_res;
  logic [CW-1:0] sweep_left;
  logic [CW-1:0] mv_li_init;
  logic [IW-1:0] mv_ptr_init;
  logic [IW-1:0] head_addr;
  state_t        shift_next;
  logic [CW-1:0] fcnt_c;
  logic [ID_W-1:0] fearly_c;

  edfq_ram #(
    .DEPTH(CAPACITY),
    .AW   (IW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  edfq_alu u_alu (
    .a  (alu_a),
    .b  (alu_b),
    .res(alu)
  );

  assign is_rel   = (act == ACT_RELEASE);
  assign is_cmp   = (act == ACT_COMPLETE);
  assign full     = (n1 == CW'(CAPACITY));
  assign rel_ok   = is_rel && !full;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // The table is sorted, so overdue tasks always form a prefix of it.
  assign scan_re  = (idx < lim);
  always_comb begin
    if (state == ST_SWEEP) begin
      scan_hit = rv && !alu.lt;
    end else if (is_rel) begin
      scan_hit = rv && alu.lt;
    end else begin
      scan_hit = rv && alu.eq;
    end
  end
  assign scan_end   = scan_hit || (rv && (ridx == lim - CW'(1))) || (lim == '0);
  assign scan_res   = scan_hit ? ridx : lim;
  assign sweep_left = cnt - scan_res;

  // An insert moves entries toward the tail from the back; a removal moves
  // the entries behind the hole one place toward the head.
  assign mv_li_init  = is_rel ? n1 - CW'(1) : pos + CW'(1);
  assign mv_ptr_init = wrap_add(hd1, mv_li_init);
  assign head_addr   = wrap_add(hd1, (is_cmp && found && (pos == '0)) ? CW'(1) : '0);

  always_comb begin
    if (rel_ok) begin
      shift_next = (pos == n1) ? ST_INS_WR : ST_MV_RD;
    end else if (is_cmp && found && ((CW+1)'(pos) + (CW+1)'(1) < (CW+1)'(n1))) begin
      shift_next = ST_MV_RD;
    end else begin
      shift_next = ST_FIN;
    end
  end

  always_comb begin
    if (rel_ok) begin
      fcnt_c = n1 + CW'(1);
    end else if (is_cmp && found) begin
      fcnt_c = n1 - CW'(1);
    end else begin
      fcnt_c = n1;
    end
  end

  always_comb begin
    if (fcnt_c == '0) begin
      fearly_c = '0;
    end else if (rel_ok && (pos == '0)) begin
      fearly_c = tid;
    end else begin
      fearly_c = rdata.id;
    end
  end

  always_comb begin
    if (state == ST_SWEEP) begin
      alu_a = rdata.deadline;
      alu_b = cur_tick;
    end else if (state == ST_SEARCH && is_rel) begin
      alu_a = new_dl;
      alu_b = rdata.deadline;
    end else if (state == ST_SEARCH) begin
      alu_a = TICK_W'(tid);
      alu_b = TICK_W'(rdata.id);
    end else begin
      alu_a = cur_tick;
      alu_b = hit_rel;
    end
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = ptr;
    ram_we    = 1'b0;
    ram_waddr = wrap_add(hd1, pos);
    ram_wdata = '{id: tid, deadline: new_dl, rel_tick: cur_tick};
    unique case (state)
      ST_SWEEP, ST_SEARCH: ram_re = scan_re;
      ST_HEAD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = head_addr;
      end
      ST_OVD_RD, ST_MV_RD: ram_re = 1'b1;
      ST_MV_WR: begin
        ram_we    = 1'b1;
        ram_waddr = is_rel ? wrap_inc(ptr) : wrap_dec(ptr);
        ram_wdata = rdata;
      end
      ST_INS_WR: ram_we = 1'b1;
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (scan_end) begin
          if ((!is_rel && !is_cmp) || (is_rel && sweep_left == CW'(CAPACITY))) begin
            state_next = ST_HEAD_RD;
          end else begin
            state_next = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (scan_end) state_next = ST_HEAD_RD;
      end
      ST_HEAD_RD: state_next = ST_HEAD_WT;
      ST_HEAD_WT: state_next = (m != '0) ? ST_OVD_RD : shift_next;
      ST_OVD_RD:  state_next = ST_OVD_OUT;
      ST_OVD_OUT: begin
        if (out_free) state_next = (idx + CW'(1) == m) ? shift_next : ST_OVD_RD;
      end
      ST_MV_RD: state_next = ST_MV_WR;
      ST_MV_WR: begin
        if (is_rel) begin
          state_next = (li == pos) ? ST_INS_WR : ST_MV_RD;
        end else begin
          state_next = (li == n1 - CW'(1)) ? ST_FIN : ST_MV_RD;
        end
      end
      ST_INS_WR: state_next = ST_FIN;
      ST_FIN: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      head     <= '0;
      cnt      <= '0;
    end else begin
      state <= state_next;
      if ((state == ST_OVD_OUT || state == ST_FIN) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == ST_FIN && out_free) begin
        head <= hd1;
        cnt  <= fcnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          act      <= s_tuser;
          tid      <= s_tdata[ID_W-1:0];
          cur_tick <= s_tdata[ID_W+2*TICK_W-1:ID_W+TICK_W];
          new_dl   <= s_tdata[ID_W+TICK_W-1:ID_W] + s_tdata[ID_W+2*TICK_W-1:ID_W+TICK_W];
          ptr      <= head;
          idx      <= '0;
          rv       <= 1'b0;
          lim      <= cnt;
        end
      end
      ST_SWEEP, ST_SEARCH: begin
        if (scan_re) begin
          ptr <= wrap_inc(ptr);
          idx <= idx + CW'(1);
        end
        rv   <= scan_re;
        ridx <= idx;
        if (scan_end && state == ST_SWEEP) begin
          m     <= scan_res;
          hd1   <= wrap_add(head, scan_res);
          n1    <= sweep_left;
          ptr   <= wrap_add(head, scan_res);
          idx   <= '0;
          rv    <= 1'b0;
          lim   <= sweep_left;
          pos   <= '0;
          found <= 1'b0;
        end else if (scan_end) begin
          pos     <= scan_res;
          found   <= scan_hit;
          hit_rel <= rdata.rel_tick;
          hit_dl  <= rdata.deadline;
        end
      end
      ST_HEAD_WT: begin
        fcnt   <= fcnt_c;
        fearly <= fearly_c;
        idx    <= '0;
        li     <= mv_li_init;
        ptr    <= (m != '0) ? head : mv_ptr_init;
      end
      ST_OVD_OUT: begin
        if (out_free) begin
          idx <= idx + CW'(1);
          if (idx + CW'(1) == m) begin
            ptr <= mv_ptr_init;
          end else begin
            ptr <= wrap_inc(ptr);
          end
        end
      end
      ST_MV_WR: begin
        if (is_rel) begin
          li  <= li - CW'(1);
          ptr <= wrap_dec(ptr);
        end else begin
          li  <= li + CW'(1);
          ptr <= wrap_inc(ptr);
        end
      end
      default: begin
        rv <= 1'b0;
      end
    endcase
  end

  // Output payload; every result of one request carries the final table view.
  always_ff @(posedge clk) begin
    if (out_free && (state == ST_OVD_OUT || state == ST_FIN)) begin
      o_early <= fearly;
      o_any   <= (fcnt != '0);
      o_cnt   <= COUNT_W'(fcnt);
      o_el    <= '0;
      if (state == ST_OVD_OUT) begin
        o_kind <= KIND_OVERDUE;
        o_id   <= rdata.id;
        o_dl   <= rdata.deadline;
        o_last <= 1'b0;
      end else begin
        o_last <= 1'b1;
        o_id   <= tid;
        if (is_rel && full) begin
          o_kind <= KIND_FULL;
          o_dl   <= new_dl;
        end else if (is_rel) begin
          o_kind <= KIND_RELEASED;
          o_dl   <= new_dl;
        end else if (is_cmp && found) begin
          o_kind <= KIND_COMPLETED;
          o_el   <= alu.diff;
          o_dl   <= hit_dl;
        end else if (is_cmp) begin
          o_kind <= KIND_NOT_FOUND;
          o_dl   <= '0;
        end else begin
          o_kind <= KIND_POLL_DONE;
          o_id   <= '0;
          o_dl   <= '0;
        end
      end
    end
  end

  assign m_tdata = {2'b00, o_cnt, o_any, o_early, o_dl, o_el, o_id};
  assign m_tuser = o_kind;
  assign m_tlast = o_last;

  `EDFQ_CHK_NOW(a_cnt_bound, 1'b1, cnt <= CW'(CAPACITY), "active count above capacity")
  `EDFQ_CHK_NEXT(a_accept_sweep, s_tvalid && s_tready, state == ST_SWEEP, "request did not start a sweep")
  `EDFQ_CHK_NEXT(a_fin_last, (state == ST_FIN) && out_free, m_tvalid && m_tlast && (state == ST_IDLE), "final result not marked last")
  `EDFQ_CHK_NOW(a_ovd_bound, state == ST_OVD_OUT, idx < m, "more overdue results than swept tasks")
  `EDFQ_CHK_NOW(a_sweep_shrinks, state == ST_HEAD_WT, n1 <= cnt, "sweep grew the table")

endmodule

/* dv/tb.sv */
// Self-checking testbench for the deadline-ordered task ready table core.
`timescale 1ns / 1ps

module tb;
  import edfq_pkg::*;

  localparam int DEPTH = DEF_CAPACITY;
  localparam int CYCLE_LIMIT = 800000;
  localparam int DRAIN_CYCLES = 300;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AFTER_REQS = 150;

  localparam logic [ACTION_W-1:0] ACT_POLL  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

  localparam int RX_FREE   = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_BURSTY = 2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ID_W-1:0]     id;
    logic [TICK_W-1:0]   offset;
    logic [TICK_W-1:0]   now;
  } sched_req_t;

  typedef struct packed {
    kind_t               kind;
    logic [ID_W-1:0]     id;
    logic [TICK_W-1:0]   elapsed;
    logic [TICK_W-1:0]   deadline;
    logic [ID_W-1:0]     earliest;
    logic                any_active;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } sched_res_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [ACTION_W-1:0]   s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]     m_tuser;
  logic                  m_tlast;

  edf_task_ready_table_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow copy of the ready table, kept in deadline order.
  logic [ID_W-1:0]   tbl_id  [DEPTH];
  logic [TICK_W-1:0] tbl_dl  [DEPTH];
  logic [TICK_W-1:0] tbl_rel [DEPTH];
  int                tbl_n = 0;

  sched_req_t pend_reqs[$];
  sched_res_t due_results[$];
  sched_req_t cur_req;

  int mismatches = 0;
  int reqs_done = 0;
  int results_seen = 0;
  int kind_seen[8] = '{default: 0};
  int cycles = 0;

  function automatic sched_res_t mk_result(kind_t kind, logic [ID_W-1:0] id,
                                           logic [TICK_W-1:0] elapsed,
                                           logic [TICK_W-1:0] deadline);
    sched_res_t r;
    r.kind = kind;
    r.id = id;
    r.elapsed = elapsed;
    r.deadline = deadline;
    r.earliest = '0;
    r.any_active = 1'b0;
    r.count = '0;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < tbl_n; i++) begin
      tbl_id[i] = tbl_id[i + 1];
      tbl_dl[i] = tbl_dl[i + 1];
      tbl_rel[i] = tbl_rel[i + 1];
    end
    tbl_n--;
  endfunction

  // Computes the results of one request and updates the shadow table.
  task automatic predict_schedule(input sched_req_t rq);
    sched_res_t batch[$];
    int i;
    int pos;
    logic [TICK_W-1:0] dl;
    i = 0;
    while (i < tbl_n) begin
      if (tbl_dl[i] < rq.now) begin
        batch.push_back(mk_result(KIND_OVERDUE, tbl_id[i], '0, tbl_dl[i]));
        drop_entry(i);
      end else begin
        i++;
      end
    end
    if (rq.action == ACT_RELEASE) begin
      dl = rq.now + rq.offset;
      if (tbl_n >= DEPTH) begin
        batch.push_back(mk_result(KIND_FULL, rq.id, '0, dl));
      end else begin
        pos = 0;
        while (pos < tbl_n && tbl_dl[pos] <= dl) pos++;
        for (i = tbl_n; i > pos; i--) begin
          tbl_id[i] = tbl_id[i - 1];
          tbl_dl[i] = tbl_dl[i - 1];
          tbl_rel[i] = tbl_rel[i - 1];
        end
        tbl_id[pos] = rq.id;
        tbl_dl[pos] = dl;
        tbl_rel[pos] = rq.now;
        tbl_n++;
        batch.push_back(mk_result(KIND_RELEASED, rq.id, '0, dl));
      end
    end else if (rq.action == ACT_COMPLETE) begin
      pos = 0;
      while (pos < tbl_n && tbl_id[pos] != rq.id) pos++;
      if (pos < tbl_n) begin
        batch.push_back(mk_result(KIND_COMPLETED, rq.id, rq.now - tbl_rel[pos],
                                  tbl_dl[pos]));
        drop_entry(pos);
      end else begin
        batch.push_back(mk_result(KIND_NOT_FOUND, rq.id, '0, '0));
      end
    end else begin
      batch.push_back(mk_result(KIND_POLL_DONE, '0, '0, '0));
    end
    // Every result of a request reports the table as it stands afterwards.
    foreach (batch[k]) begin
      batch[k].earliest = (tbl_n > 0) ? tbl_id[0] : '0;
      batch[k].any_active = (tbl_n > 0);
      batch[k].count = COUNT_W'(tbl_n);
      batch[k].last = (k == batch.size() - 1);
      due_results.push_back(batch[k]);
    end
  endtask

  // Request driver: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        predict_schedule(cur_req);
        reqs_done++;
      end
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pend_reqs.size() > 0) begin
        cur_req = pend_reqs.pop_front();
        s_tdata <= {cur_req.now, cur_req.offset, cur_req.id};
        s_tuser <= cur_req.action;
        s_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 10);
          gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: switches between free flow, random stalls and stall bursts.
  int rx_cycle = 0;
  int rx_mode = RX_FREE;
  int hold_left = 0;
  bit long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 80 == 0) rx_mode = $urandom_range(RX_FREE, RX_BURSTY);
      // One long hold-off lets the block fill up and stall the request side.
      if (!long_hold_done && reqs_done >= HOLD_AFTER_REQS) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE: m_tready <= 1'b1;
          RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
          default: begin
            if ($urandom_range(0, 5) == 0) begin
              hold_left = $urandom_range(1, 8);
              m_tready <= 1'b0;
            end else begin
              m_tready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [TICK_W-1:0] want,
                             input logic [TICK_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  sched_res_t want_res;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (!$isunknown(m_tuser)) kind_seen[m_tuser]++;
      if (due_results.size() == 0) begin
        $error("result with no request behind it: kind %0d id %0h", m_tuser, m_tdata[7:0]);
        mismatches++;
      end else begin
        want_res = due_results.pop_front();
        check_field("kind", want_res.kind, m_tuser);
        check_field("out_task_id", want_res.id, m_tdata[7:0]);
        check_field("elapsed_ticks", want_res.elapsed, m_tdata[39:8]);
        check_field("task_deadline", want_res.deadline, m_tdata[71:40]);
        check_field("earliest_id", want_res.earliest, m_tdata[79:72]);
        check_field("any_active", want_res.any_active, m_tdata[80]);
        check_field("active_count", want_res.count, m_tdata[85:81]);
        check_field("last", want_res.last, m_tlast);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycles,
               due_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_req(input logic [ACTION_W-1:0] action, input logic [ID_W-1:0] id,
                           input logic [TICK_W-1:0] offset,
                           input logic [TICK_W-1:0] now);
    sched_req_t rq;
    rq.action = action;
    rq.id = id;
    rq.offset = offset;
    rq.now = now;
    pend_reqs.push_back(rq);
  endtask

  // Holds the sender back until every queued request has produced its results.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pend_reqs.size() != 0 || s_tvalid || due_results.size() != 0);
  endtask

  logic [TICK_W-1:0] gen_now = '0;
  logic [ID_W-1:0]   gen_ids[$];

  // Random traffic: the tick mostly creeps forward so tasks live for a while,
  // with phases that favor releases (to fill the table) or completions.
  task automatic queue_random(input int count);
    int pick;
    bit fill_phase;
    logic [ACTION_W-1:0] action;
    logic [ID_W-1:0] id;
    logic [TICK_W-1:0] offset;
    for (int n = 0; n < count; n++) begin
      fill_phase = ((n / 60) % 2 == 0);
      pick = $urandom_range(0, 99);
      if (pick < (fill_phase ? 65 : 30)) action = ACT_RELEASE;
      else if (pick < 85) action = ACT_COMPLETE;
      else if (pick < 96) action = ACT_POLL;
      else action = ACT_SPARE;

      pick = $urandom_range(0, 99);
      if (pick < 85) gen_now += $urandom_range(0, 20);
      else if (pick < 93) gen_now -= $urandom_range(0, 5);
      else if (pick < 98) gen_now = $urandom;
      else gen_now = 32'hFFFF_FFFF - $urandom_range(0, 50);

      pick = $urandom_range(0, 99);
      if (pick < 60) offset = $urandom_range(1, 300);
      else if (pick < 85) offset = $urandom_range(0, 20);
      else if (pick < 95) offset = $urandom;
      else if (pick < 98) offset = '0;
      else offset = 32'hFFFF_FFFF;

      pick = $urandom_range(0, 99);
      if (action == ACT_COMPLETE && gen_ids.size() > 0 && pick < 75) begin
        id = gen_ids[$urandom_range(0, gen_ids.size() - 1)];
      end else if (pick < 80) begin
        id = $urandom_range(0, 31);
      end else begin
        id = $urandom_range(0, 255);
      end
      if (action == ACT_RELEASE) begin
        gen_ids.push_back(id);
        if (gen_ids.size() > 24) void'(gen_ids.pop_front());
      end
      queue_req(action, id, offset, gen_now);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty table, deadline wrap, equal deadlines, duplicate ids, spare action.
    queue_req(ACT_POLL, 8'h00, '0, '0);
    queue_req(ACT_COMPLETE, 8'h5A, '0, '0);
    queue_req(ACT_RELEASE, 8'h00, '0, '0);
    queue_req(ACT_RELEASE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(ACT_RELEASE, 8'h07, 32'hFFFF_FFFE, '0);
    queue_req(ACT_COMPLETE, 8'hFF, '0, 32'd5);
    queue_req(ACT_SPARE, 8'hC3, 32'hA5A5_A5A5, 32'd10);
    queue_req(ACT_RELEASE, 8'h07, 32'd100, 32'd10);
    queue_req(ACT_COMPLETE, 8'h07, '0, 32'd20);
    queue_req(ACT_POLL, 8'h00, '0, 32'hFFFF_FFFF);
    // Fill the table, overflow it, then expire every entry in one sweep.
    for (int k = 0; k < DEPTH; k++) begin
      queue_req(ACT_RELEASE, ID_W'(8'h10 + k), 32'd1000 + ((k * 5) % 4) * 10, 32'd100);
    end
    queue_req(ACT_RELEASE, 8'hAA, 32'd1, 32'd100);
    queue_req(ACT_POLL, 8'h00, '0, 32'hFFFF_FFFF);
    wait_drained();

    gen_now = 32'd200;
    queue_random(221);
    wait_drained();
    queue_random(221);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (due_results.size() != 0) begin
      $error("%0d expected results never arrived", due_results.size());
      mismatches++;
    end
    $display("Ran %0d requests, checked %0d results in %0d cycles.", reqs_done,
             results_seen, cycles);
    $display("Released %0d, completed %0d, overdue %0d, unknown id %0d, full %0d, poll %0d.",
             kind_seen[KIND_RELEASED], kind_seen[KIND_COMPLETED], kind_seen[KIND_OVERDUE],
             kind_seen[KIND_NOT_FOUND], kind_seen[KIND_FULL], kind_seen[KIND_POLL_DONE]);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
